// File: src/srsw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the selective repeat sender window.
// No dependencies; the top level and the checker import this package.
package srsw_pkg;

   // Default sizes handed to the top level parameters.
   localparam int MAX_FRAMES_DEF = 64;
   localparam int WINDOW_MAX_DEF = 8;

   // Fixed field widths of the interface.
   localparam int CMD_W      = 1;
   localparam int ACK_W      = 7;
   localparam int FRAME_W    = 7;
   localparam int WSIZE_W    = 4;
   localparam int FTOTAL_W   = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   // Largest values that the configuration fields can carry.
   localparam int WSIZE_FIELD_MAX  = (1 << WSIZE_W) - 1;
   localparam int FTOTAL_FIELD_MAX = (1 << FTOTAL_W) - 1;

   // Configuration register indexes and their reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TOTAL = 1'd1;
   localparam logic [WSIZE_W-1:0]   WINDOW_SIZE_RST = 4'd3;
   localparam logic [FTOTAL_W-1:0]  FRAME_TOTAL_RST = 7'd6;

   // Command codes of an input item.
   localparam logic [CMD_W-1:0] CMD_RESEND = 1'b0;
   localparam logic [CMD_W-1:0] CMD_ACK    = 1'b1;

   // One input item.
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [ACK_W-1:0] ack_number;
   } req_type;

   // One result item.
   typedef struct packed {
      logic               frame_valid;
      logic [FRAME_W-1:0] frame_number;
      logic               last;
      logic               all_acked;
   } rsp_type;

endpackage

// File: src/srsw_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module srsw_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/selective_repeat_sender_window.sv
`timescale 1ns / 1ps
// Selective repeat ARQ sender window: acknowledgement map, base slide and window scan.
// Depends on srsw_pkg and srsw_ram.
//
// Each input item is a resend request or an acknowledgement. The block records the
// acknowledgement, slides the window base past acknowledged frames and then emits every
// unacknowledged frame of the window in ascending order, the final one flagged last, or a
// single completion item once all frames are acknowledged. The acknowledgement map sits in
// a RAM with one read port, and a small sequencer reads it one frame at a time. For each
// item the sequencer reads and tests the map entry of every frame the base slides over,
// then reads and tests each later frame of the window, and each result waits while the
// result side stalls. The block accepts no item while it works on one. After reset a
// clearing pass writes every map entry (MAX_FRAMES of them, at most 127) before the first
// item is accepted; configuration writes are taken throughout.
module selective_repeat_sender_window
   import srsw_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // Result items
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // Configuration writes
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   // Frame totals beyond what the field can carry are unreachable.
   localparam int TOTAL_CAP = (MAX_FRAMES < FTOTAL_FIELD_MAX) ? MAX_FRAMES : FTOTAL_FIELD_MAX;
   localparam int WIN_CAP   = (WINDOW_MAX < WSIZE_FIELD_MAX) ? WINDOW_MAX : WSIZE_FIELD_MAX;
   localparam int MAP_DEPTH = TOTAL_CAP;
   localparam int IDX_W     = $clog2(MAP_DEPTH);
   localparam int BASE_W    = $clog2(TOTAL_CAP + 2);
   localparam int WIN_W     = $clog2(WIN_CAP + 1);
   localparam int NUM_W     = (BASE_W > ACK_W) ? BASE_W : ACK_W;
   localparam int SUM_W     = ((BASE_W > WIN_W) ? BASE_W : WIN_W) + 1;

   // Sequencer states, one-hot.
   typedef enum logic [7:0] {
      ST_CLEAR     = 8'b0000_0001,
      ST_IDLE      = 8'b0000_0010,
      ST_SLIDE     = 8'b0000_0100,
      ST_SLIDE_CHK = 8'b0000_1000,
      ST_SCAN_RD   = 8'b0001_0000,
      ST_SCAN_CHK  = 8'b0010_0000,
      ST_FLUSH     = 8'b0100_0000,
      ST_COMPLETE  = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [WSIZE_W-1:0]    window_size_ff;
   logic [FTOTAL_W-1:0]   frame_total_ff;
   logic [IDX_W-1:0]      clear_cnt_ff, clear_cnt_in;
   logic [BASE_W-1:0]     base_ff, base_in;
   logic [BASE_W-1:0]     scan_ff, scan_in;
   logic [BASE_W-1:0]     pending_ff, pending_in;
   logic [BASE_W-1:0]     end_ff, end_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  out_free;
   logic [BASE_W-1:0]     total_eff;
   logic [WIN_W-1:0]      win_eff;
   logic [SUM_W-1:0]      end_sum;
   logic [BASE_W-1:0]     end_calc;
   logic [ACK_W-1:0]      ack_m1;
   logic                  ack_in_range;
   logic [BASE_W-1:0]     base_m1;
   logic [BASE_W-1:0]     scan_m1;

   logic                  map_wr_en;
   logic [IDX_W-1:0]      map_wr_addr;
   logic                  map_wr_data;
   logic                  map_rd_en;
   logic [IDX_W-1:0]      map_rd_addr;
   logic                  map_rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RST;
         frame_total_ff <= FRAME_TOTAL_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_ff <= csr_write_data[WSIZE_W-1:0];
            CSR_FRAME_TOTAL: frame_total_ff <= csr_write_data[FTOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective total and window: zero acts as one, large values saturate.
   always_comb begin
      if (frame_total_ff == '0) begin
         total_eff = BASE_W'(1);
      end else if (NUM_W'(frame_total_ff) > NUM_W'(TOTAL_CAP)) begin
         total_eff = BASE_W'(TOTAL_CAP);
      end else begin
         total_eff = BASE_W'(frame_total_ff);
      end
      if (window_size_ff == '0) begin
         win_eff = WIN_W'(1);
      end else if (window_size_ff > WSIZE_W'(WIN_CAP)) begin
         win_eff = WIN_W'(WIN_CAP);
      end else begin
         win_eff = WIN_W'(window_size_ff);
      end
   end

   // Handshake on both channels.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // An acknowledgement counts only for a frame within the effective total.
   assign ack_m1       = req_data.ack_number - ACK_W'(1);
   assign ack_in_range = (req_data.command == CMD_ACK) && (req_data.ack_number != '0) &&
                         (NUM_W'(req_data.ack_number) <= NUM_W'(total_eff));

   // Last frame of the window: the base plus the window less one, capped at the total.
   assign end_sum  = SUM_W'(base_ff) + SUM_W'(win_eff) - SUM_W'(1);
   assign end_calc = (end_sum > SUM_W'(total_eff)) ? total_eff : BASE_W'(end_sum);

   assign base_m1 = base_ff - BASE_W'(1);
   assign scan_m1 = scan_ff - BASE_W'(1);

   // Map write port: the clearing pass, else an acknowledgement at accept.
   always_comb begin
      map_wr_en   = 1'b0;
      map_wr_addr = clear_cnt_ff;
      map_wr_data = 1'b0;
      if (state_ff == ST_CLEAR) begin
         map_wr_en = 1'b1;
      end else if (req_accept && ack_in_range) begin
         map_wr_en   = 1'b1;
         map_wr_addr = IDX_W'(ack_m1);
         map_wr_data = 1'b1;
      end
   end

   // Map read port: the base while sliding, the scan pointer while scanning.
   assign map_rd_en   = ((state_ff == ST_SLIDE) && (base_ff <= total_eff)) ||
                        ((state_ff == ST_SCAN_RD) && (scan_ff <= end_ff));
   assign map_rd_addr = (state_ff == ST_SCAN_RD) ? IDX_W'(scan_m1) : IDX_W'(base_m1);

   srsw_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // Sequencer: clear, slide the base, scan the window, emit items.
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      base_in      = base_ff;
      scan_in      = scan_ff;
      pending_in   = pending_ff;
      end_in       = end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + IDX_W'(1);
            if (clear_cnt_ff == IDX_W'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SLIDE;
            end
         end
         ST_SLIDE: begin
            if (base_ff > total_eff) begin
               state_in = ST_COMPLETE;
            end else begin
               state_in = ST_SLIDE_CHK;
            end
         end
         ST_SLIDE_CHK: begin
            if (map_rd_data) begin
               base_in  = base_ff + BASE_W'(1);
               state_in = ST_SLIDE;
            end else begin
               // The base is the first frame to send; hold it until the next is known.
               pending_in = base_ff;
               scan_in    = base_ff + BASE_W'(1);
               end_in     = end_calc;
               state_in   = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff > end_ff) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (map_rd_data) begin
               scan_in  = scan_ff + BASE_W'(1);
               state_in = ST_SCAN_RD;
            end else if (out_free) begin
               // Another frame follows, so the held one is not the last.
               rsp_valid_in             = 1'b1;
               rsp_data_in.frame_valid  = 1'b1;
               rsp_data_in.frame_number = FRAME_W'(pending_ff);
               rsp_data_in.last         = 1'b0;
               rsp_data_in.all_acked    = 1'b0;
               pending_in               = scan_ff;
               scan_in                  = scan_ff + BASE_W'(1);
               state_in                 = ST_SCAN_RD;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.frame_valid  = 1'b1;
               rsp_data_in.frame_number = FRAME_W'(pending_ff);
               rsp_data_in.last         = 1'b1;
               rsp_data_in.all_acked    = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         ST_COMPLETE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.frame_valid  = 1'b0;
               rsp_data_in.frame_number = '0;
               rsp_data_in.last         = 1'b1;
               rsp_data_in.all_acked    = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         base_ff      <= BASE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working values and the output item.
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      pending_ff  <= pending_in;
      end_ff      <= end_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/srsw_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the selective repeat sender window, with the bind to the top level.
// Depends on srsw_pkg and selective_repeat_sender_window.
module srsw_checker
   import srsw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled item stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   // A frame item names a real frame and never reports completion.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_valid |->
         !rsp_data.all_acked && (rsp_data.frame_number != '0))
      else $error("frame item carries no frame or claims completion");

   // The completion item is alone: no frame and always last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.all_acked |->
         !rsp_data.frame_valid && rsp_data.last && (rsp_data.frame_number == '0))
      else $error("malformed completion item");

   // Every item is either a frame or the completion report.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_valid |-> rsp_data.all_acked)
      else $error("item is neither a frame nor completion");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
